// ===== sv/swap_slot_table_top_macros.svh =====
// Assertion macros for the swap slot table.
// Used by swap_slot_table_top; compiled out when SYNTHESIS is defined.
`ifndef SWAP_SLOT_TABLE_TOP_MACROS_SVH
`define SWAP_SLOT_TABLE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SSL_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
	else $error(msg);
`define SSL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
	else $error(msg);
`else
`define SSL_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define SSL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== sv/ssl_pkg.sv =====
// Shared types and constants of the swap slot table.
// No dependencies; imported by ssl_if, swap_slot_table_top, ssl_cell and ssl_scan.
package ssl_pkg;

	localparam int SLOTS_DEF      = 64;
	localparam int OWNER_BITS_DEF = 8;
	localparam int PAGE_BITS_DEF  = 12;

	localparam int REQ_TYPE_W    = 3;
	localparam int OWNER_ID_W    = 8;
	localparam int PAGE_NUMBER_W = 12;
	localparam int SLOT_INDEX_W  = 6;
	localparam int STATUS_W      = 2;
	localparam int SLOT_W        = 6;
	localparam int COUNT_W       = 7;

	// cells examined per scan cycle, power of two
	localparam int GROUP = 8;

	localparam logic [REQ_TYPE_W-1:0] REQ_ADD          = 3'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_FIND         = 3'd1;
	localparam logic [REQ_TYPE_W-1:0] REQ_REMOVE_OWNER = 3'd2;
	localparam logic [REQ_TYPE_W-1:0] REQ_ALLOCATE     = 3'd3;
	localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR        = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_APPLY
	} fsm_state_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_CLAIM_OWNED,
		CMD_CLAIM_ANON,
		CMD_REMOVE_OWNER,
		CMD_CLEAR
	} cell_cmd_t;

	typedef struct packed {
		logic hit;
		logic free;
		logic rm;
	} cell_flags_t;

endpackage

// ===== sv/ssl_if.sv =====
// Request and response channel interfaces of the swap slot table.
// Depends on ssl_pkg for field widths.
interface ssl_req_if import ssl_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [REQ_TYPE_W-1:0]    req_type;
	logic [OWNER_ID_W-1:0]    owner_id;
	logic [PAGE_NUMBER_W-1:0] page_number;
	logic [SLOT_INDEX_W-1:0]  slot_index;

	modport source (output valid, req_type, owner_id, page_number, slot_index, input ready);
	modport sink (input valid, req_type, owner_id, page_number, slot_index, output ready);
endinterface

interface ssl_rsp_if import ssl_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                was_present;
	logic [SLOT_W-1:0]   slot;
	logic [COUNT_W-1:0]  freed_count;
	logic [COUNT_W-1:0]  free_slots;

	modport source (output valid, status, was_present, slot, freed_count, free_slots,
		input ready);
	modport sink (input valid, status, was_present, slot, freed_count, free_slots,
		output ready);
endinterface

// ===== sv/swap_slot_table_top.sv =====
// Swap slot table top level: request FSM, row of slot cells, scan unit.
// Depends on ssl_pkg, ssl_if, ssl_cell, ssl_scan and the assertion macros.
//
// Usage:
//   req carries one item per request: req_type (add, find, remove owner,
//   allocate, clear), owner_id, page_number and slot_index. rsp returns
//   exactly one item per request: status, was_present, slot, freed_count
//   and free_slots (unused slots after the request).
//   Both channels move an item when valid and ready are high at a clock edge.
//   The owner and page of every slot are compared in parallel, one cell per
//   slot; the scan unit then walks the cell flags eight slots per cycle to
//   find the lowest hit, the lowest free slot and the counts.
//   After acceptance the scan unit walks the groups in order, then the apply
//   state updates the table and loads the output register that drives rsp.
//   One request is in flight at a time.
//   A new request may be accepted while the previous result waits in the
//   output register; the table update waits until that register is free.
//   Reset (arst_n low) empties the table at once: every slot is free.
//   A stalled rsp holds its item stable until taken.
`include "swap_slot_table_top_macros.svh"
module swap_slot_table_top import ssl_pkg::*; #(
	parameter int SLOTS      = SLOTS_DEF,
	parameter int OWNER_BITS = OWNER_BITS_DEF,
	parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ssl_req_if.sink   req,
	ssl_rsp_if.source rsp
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);

	fsm_state_t state_q, state_d;

	logic [REQ_TYPE_W-1:0]    req_type_q;
	logic [OWNER_ID_W-1:0]    owner_id_q;
	logic [PAGE_NUMBER_W-1:0] page_number_q;
	logic [SLOT_INDEX_W-1:0]  slot_index_q;

	logic [31:0] owner_ext, page_ext, clr_ext, slot_ext, freed_ext, free_ext;
	logic [OWNER_BITS-1:0] owner_w;
	logic [PAGE_BITS-1:0]  page_w;

	logic accept, scan_start, apply_fire;
	logic scan_done, hit_found, free_found;
	logic [IDX_W-1:0] hit_idx, free_idx;
	logic [CNT_W-1:0] free_cnt, freed_cnt;

	logic [SLOTS-1:0] hit_vec, free_vec, rmu_vec;
	cell_cmd_t        cell_cmd;

	logic [STATUS_W-1:0] ap_status;
	logic                ap_present;
	logic [IDX_W-1:0]    ap_slot, ap_tgt;
	logic [CNT_W-1:0]    ap_freed, ap_free;
	cell_cmd_t           ap_cmd;
	logic                clr_in_range;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic                present_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [COUNT_W-1:0]  freed_q, free_q;

	assign owner_ext = 32'(owner_id_q);
	assign page_ext  = 32'(page_number_q);
	assign clr_ext   = 32'(slot_index_q);
	assign owner_w   = owner_ext[OWNER_BITS-1:0];
	assign page_w    = page_ext[PAGE_BITS-1:0];

	// FSM
	assign accept = req.valid && req.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE:  if (accept) state_d = FSM_SCAN;
			FSM_SCAN:  if (scan_done) state_d = FSM_APPLY;
			FSM_APPLY: if (apply_fire) state_d = FSM_IDLE;
			default:   state_d = FSM_IDLE;
		endcase
	end

	always_comb begin
		req.ready  = 1'b0;
		apply_fire = 1'b0;
		case (state_q)
			FSM_IDLE:  req.ready = 1'b1;
			FSM_APPLY: apply_fire = !out_valid_q || rsp.ready;
			default: begin
			end
		endcase
	end

	assign scan_start = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= FSM_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q    <= req.req_type;
			owner_id_q    <= req.owner_id;
			page_number_q <= req.page_number;
			slot_index_q  <= req.slot_index;
		end
	end

	// slot cells
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		cell_flags_t flags;

		ssl_cell #(
			.OWNER_BITS (OWNER_BITS),
			.PAGE_BITS  (PAGE_BITS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.owner  (owner_w),
			.page   (page_w),
			.cmd    (cell_cmd),
			.sel    (ap_tgt == IDX_W'(i)),
			.flags  (flags)
		);

		assign hit_vec[i]  = flags.hit;
		assign free_vec[i] = flags.free;
		assign rmu_vec[i]  = flags.rm && !flags.free;
	end

	ssl_scan #(
		.SLOTS (SLOTS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (scan_start),
		.hit_vec    (hit_vec),
		.free_vec   (free_vec),
		.rmu_vec    (rmu_vec),
		.done       (scan_done),
		.hit_found  (hit_found),
		.hit_idx    (hit_idx),
		.free_found (free_found),
		.free_idx   (free_idx),
		.free_cnt   (free_cnt),
		.freed_cnt  (freed_cnt)
	);

	// result and table update
	assign clr_in_range = clr_ext < 32'(SLOTS);

	always_comb begin
		ap_status  = ST_OK;
		ap_present = 1'b0;
		ap_slot    = '0;
		ap_freed   = '0;
		ap_free    = free_cnt;
		ap_cmd     = CMD_NONE;
		ap_tgt     = '0;
		case (req_type_q)
			REQ_ADD: begin
				if (hit_found) begin
					ap_present = 1'b1;
					ap_slot    = hit_idx;
				end else if (free_found) begin
					ap_slot = free_idx;
					ap_tgt  = free_idx;
					ap_cmd  = CMD_CLAIM_OWNED;
					ap_free = free_cnt - CNT_W'(1);
				end else begin
					ap_status = ST_FULL;
				end
			end
			REQ_FIND: begin
				if (hit_found)
					ap_slot = hit_idx;
				else
					ap_status = ST_NOT_FOUND;
			end
			REQ_REMOVE_OWNER: begin
				ap_cmd   = CMD_REMOVE_OWNER;
				ap_freed = freed_cnt;
				ap_free  = free_cnt + freed_cnt;
			end
			REQ_ALLOCATE: begin
				if (free_found) begin
					ap_slot = free_idx;
					ap_tgt  = free_idx;
					ap_cmd  = CMD_CLAIM_ANON;
					ap_free = free_cnt - CNT_W'(1);
				end else begin
					ap_status = ST_FULL;
				end
			end
			REQ_CLEAR: begin
				ap_tgt = clr_ext[IDX_W-1:0];
				if (clr_in_range) begin
					ap_cmd = CMD_CLEAR;
					if (!free_vec[ap_tgt])
						ap_free = free_cnt + CNT_W'(1);
				end else begin
					ap_status = ST_NOT_FOUND;
				end
			end
			default: ap_status = ST_NOT_FOUND;
		endcase
	end

	assign cell_cmd  = apply_fire ? ap_cmd : CMD_NONE;
	assign slot_ext  = 32'(ap_slot);
	assign freed_ext = 32'(ap_freed);
	assign free_ext  = 32'(ap_free);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (apply_fire)
			out_valid_q <= 1'b1;
		else if (rsp.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (apply_fire) begin
			status_q  <= ap_status;
			present_q <= ap_present;
			slot_q    <= slot_ext[SLOT_W-1:0];
			freed_q   <= freed_ext[COUNT_W-1:0];
			free_q    <= free_ext[COUNT_W-1:0];
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.was_present = present_q;
	assign rsp.slot        = slot_q;
	assign rsp.freed_count = freed_q;
	assign rsp.free_slots  = free_q;

	`SSL_ASSERT_NEXT(a_accept_scans, clk, arst_n, accept, state_q == FSM_SCAN, "accepted item did not start a scan")
	`SSL_ASSERT_IMPLY(a_done_in_scan, clk, arst_n, scan_done, state_q == FSM_SCAN, "scan finished outside the scan state")
	`SSL_ASSERT_IMPLY(a_claim_free, clk, arst_n, cell_cmd == CMD_CLAIM_OWNED || cell_cmd == CMD_CLAIM_ANON, free_vec[ap_tgt], "claim of a used slot")
	`SSL_ASSERT_IMPLY(a_present_ok, clk, arst_n, rsp.valid && rsp.was_present, rsp.status == ST_OK, "hit reported with a failing status")

endmodule

// ===== sv/ssl_cell.sv =====
// One swap slot: used and owned bits, owner id and page number.
// Depends on ssl_pkg; instantiated once per slot by swap_slot_table_top.
module ssl_cell import ssl_pkg::*; #(
	parameter int OWNER_BITS = OWNER_BITS_DEF,
	parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [OWNER_BITS-1:0] owner,
	input  logic [PAGE_BITS-1:0]  page,
	input  cell_cmd_t             cmd,
	input  logic                  sel,
	output cell_flags_t           flags
);

	logic                  used_q;
	logic                  owned_q;
	logic [OWNER_BITS-1:0] owner_q;
	logic [PAGE_BITS-1:0]  page_q;
	logic                  owner_eq;

	assign owner_eq   = (owner_q == owner);
	assign flags.hit  = used_q && owned_q && owner_eq && (page_q == page);
	assign flags.free = !used_q;
	assign flags.rm   = owned_q && owner_eq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= 1'b0;
			owned_q <= 1'b0;
		end else begin
			case (cmd)
				CMD_CLAIM_OWNED: begin
					if (sel) begin
						used_q  <= 1'b1;
						owned_q <= 1'b1;
					end
				end
				CMD_CLAIM_ANON: begin
					if (sel) begin
						used_q  <= 1'b1;
						owned_q <= 1'b0;
					end
				end
				CMD_REMOVE_OWNER: begin
					if (flags.rm) begin
						used_q  <= 1'b0;
						owned_q <= 1'b0;
					end
				end
				CMD_CLEAR: begin
					if (sel) begin
						used_q  <= 1'b0;
						owned_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == CMD_CLAIM_OWNED && sel) begin
			owner_q <= owner;
			page_q  <= page;
		end
	end

endmodule

// ===== sv/ssl_scan.sv =====
// Group-wise scan of the slot flags: lowest hit, lowest free slot, counts.
// Depends on ssl_pkg; GROUP cells are examined per cycle.
module ssl_scan import ssl_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF,
	localparam int IDX_W = $clog2(SLOTS),
	localparam int CNT_W = $clog2(SLOTS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SLOTS-1:0] hit_vec,
	input  logic [SLOTS-1:0] free_vec,
	input  logic [SLOTS-1:0] rmu_vec,
	output logic             done,
	output logic             hit_found,
	output logic [IDX_W-1:0] hit_idx,
	output logic             free_found,
	output logic [IDX_W-1:0] free_idx,
	output logic [CNT_W-1:0] free_cnt,
	output logic [CNT_W-1:0] freed_cnt
);

	localparam int GROUPS = (SLOTS + GROUP - 1) / GROUP;
	localparam int PAD    = GROUPS * GROUP;
	localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int GSEL_W = $clog2(GROUP);
	localparam int PC_W   = $clog2(GROUP + 1);

	logic [PAD-1:0]         hit_pad, free_pad, rmu_pad;
	logic [GROUP-1:0]       hit_g, free_g, rmu_g;
	logic [GRP_W-1:0]       grp_q;
	logic                   busy_q, done_q, last;
	logic [GSEL_W-1:0]      hit_pos, free_pos;
	logic [PC_W-1:0]        free_pc, rmu_pc;
	logic [GRP_W+GSEL_W-1:0] hit_cand, free_cand;
	logic                   hit_found_q, free_found_q;
	logic [IDX_W-1:0]       hit_idx_q, free_idx_q;
	logic [CNT_W-1:0]       free_cnt_q, freed_cnt_q;

	assign hit_pad  = PAD'(hit_vec);
	assign free_pad = PAD'(free_vec);
	assign rmu_pad  = PAD'(rmu_vec);
	assign hit_g    = hit_pad[grp_q * GROUP +: GROUP];
	assign free_g   = free_pad[grp_q * GROUP +: GROUP];
	assign rmu_g    = rmu_pad[grp_q * GROUP +: GROUP];
	assign last     = (grp_q == GRP_W'(GROUPS - 1));

	always_comb begin
		hit_pos  = '0;
		free_pos = '0;
		free_pc  = '0;
		rmu_pc   = '0;
		for (int j = GROUP - 1; j >= 0; j--) begin
			if (hit_g[j])
				hit_pos = GSEL_W'(j);
			if (free_g[j])
				free_pos = GSEL_W'(j);
		end
		for (int j = 0; j < GROUP; j++) begin
			free_pc = free_pc + PC_W'(free_g[j]);
			rmu_pc  = rmu_pc + PC_W'(rmu_g[j]);
		end
	end

	assign hit_cand  = {grp_q, hit_pos};
	assign free_cand = {grp_q, free_pos};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			grp_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				grp_q  <= '0;
			end else if (busy_q) begin
				if (last)
					busy_q <= 1'b0;
				else
					grp_q <= grp_q + GRP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			hit_idx_q    <= '0;
			free_idx_q   <= '0;
			free_cnt_q   <= '0;
			freed_cnt_q  <= '0;
		end else if (busy_q) begin
			if ((|hit_g) && !hit_found_q) begin
				hit_found_q <= 1'b1;
				hit_idx_q   <= hit_cand[IDX_W-1:0];
			end
			if ((|free_g) && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= free_cand[IDX_W-1:0];
			end
			free_cnt_q  <= free_cnt_q + CNT_W'(free_pc);
			freed_cnt_q <= freed_cnt_q + CNT_W'(rmu_pc);
		end
	end

	assign done       = done_q;
	assign hit_found  = hit_found_q;
	assign hit_idx    = hit_idx_q;
	assign free_found = free_found_q;
	assign free_idx   = free_idx_q;
	assign free_cnt   = free_cnt_q;
	assign freed_cnt  = freed_cnt_q;

endmodule
